>>> design/lkw_pkg.sv
// ----------------------------------------------------------------------------
// lkw_pkg: shared types and constants of the kernel weight generator
// Kernel kinds, queue entry layout, sine series coefficients, saturation.
// ----------------------------------------------------------------------------
package lkw_pkg;

    localparam logic [2:0] MODE_NEAREST  = 3'd0;
    localparam logic [2:0] MODE_BILINEAR = 3'd1;
    localparam logic [2:0] MODE_LANCZOS2 = 3'd2;
    localparam logic [2:0] MODE_LANCZOS3 = 3'd3;
    localparam logic [2:0] MODE_LANCZOS4 = 3'd4;

    localparam logic signed [17:0] W_MAX = 18'sh1ffff;
    localparam logic signed [17:0] W_MIN = 18'sh20000;

    typedef enum logic [2:0] {
        K_NEAREST  = 3'd0,
        K_BILINEAR = 3'd1,
        K_LANCZOS  = 3'd2,
        K_IMPULSE  = 3'd3,
        K_INVALID  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  order;
        logic [15:0] pos;
    } item_t;

    // odd taylor terms of sin(pi*v), q30
    function automatic logic [32:0] sin_coef(input logic [2:0] idx);
        logic [32:0] c;
        case (idx)
            3'd0:    c = 33'd3373259426;
            3'd1:    c = 33'd5548789346;
            3'd2:    c = 33'd2738217788;
            3'd3:    c = 33'd643455389;
            3'd4:    c = 33'd88203474;
            3'd5:    c = 33'd7913940;
            3'd6:    c = 33'd500689;
            default: c = 33'd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [39:0] w);
        logic signed [17:0] r;
        if (w > 40'sd131071) begin
            r = W_MAX;
        end else if (w < -40'sd131072) begin
            r = W_MIN;
        end else begin
            r = w[17:0];
        end
        return r;
    endfunction

endpackage

>>> design/lkw_front.sv
// ----------------------------------------------------------------------------
// lkw_front: input side of the kernel weight generator
// Accepts shift/mode items, classifies the kernel and queues them (2 deep).
// ----------------------------------------------------------------------------
module lkw_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [15:0]    s_pos,
    input  logic [2:0]     s_mode,
    output logic           q_valid,
    output lkw_pkg::item_t q_item,
    input  logic           q_pop
);

    lkw_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    lkw_pkg::item_t cls;
    logic           push;

    always_comb begin
        cls.pos   = s_pos;
        cls.order = s_mode;
        case (s_mode) inside
            lkw_pkg::MODE_NEAREST:  cls.kind = lkw_pkg::K_NEAREST;
            lkw_pkg::MODE_BILINEAR: cls.kind = lkw_pkg::K_BILINEAR;
            [lkw_pkg::MODE_LANCZOS2:lkw_pkg::MODE_LANCZOS4]: begin
                // zero shift gives the centred impulse
                cls.kind = (s_pos == 16'd0) ? lkw_pkg::K_IMPULSE : lkw_pkg::K_LANCZOS;
            end
            default:                cls.kind = lkw_pkg::K_INVALID;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

>>> design/lkw_div.sv
// ----------------------------------------------------------------------------
// lkw_div: shared restoring divider
// One quotient bit per cycle; done pulses when quo holds the result.
// ----------------------------------------------------------------------------
module lkw_div #(
    parameter int DW = 56,
    parameter int VW = 37
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quo
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            rem_reg <= ge ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CW'(1));
            if (start) begin
                cnt_reg <= CW'(DW);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> design/lkw_back.sv
// ----------------------------------------------------------------------------
// lkw_back: weight engine of the kernel weight generator
// Sequences sine, raw taps, sum normalisation and the output register.
// ----------------------------------------------------------------------------
module lkw_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  lkw_pkg::item_t      q_item,
    output logic                q_pop,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [2:0]          m_tap_index,
    output logic signed [17:0]  m_weight,
    output logic                m_last,
    output logic                m_error
);

    localparam int DW = (FRAC_BITS + 38 > 56) ? FRAC_BITS + 38 : 56;
    localparam int VW = 37;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_SIMPLE = 15'h0002,
        ST_UDIV   = 15'h0004,
        ST_UWAIT  = 15'h0008,
        ST_SQ     = 15'h0010,
        ST_HORN   = 15'h0020,
        ST_VP     = 15'h0040,
        ST_M2     = 15'h0080,
        ST_QDIV   = 15'h0100,
        ST_QWAIT  = 15'h0200,
        ST_CHK    = 15'h0400,
        ST_NORM   = 15'h0800,
        ST_WDIV   = 15'h1000,
        ST_WWAIT  = 15'h2000,
        ST_WEMIT  = 15'h4000
    } state_t;

    state_t               state_reg;
    lkw_pkg::kind_t       kind_reg;
    logic [2:0]           order_reg;
    logic [15:0]          pos_reg;
    logic [2:0]           k_reg;
    logic [18:0]          m_reg;
    logic                 neg_reg;
    logic [29:0]          v_reg;
    logic [28:0]          v2_reg;
    logic [32:0]          p_reg;
    logic [2:0]           hidx_reg;
    logic [30:0]          sn_reg;
    logic [36:0]          m2_reg;
    logic [55:0]          raw_mag_reg [8];
    logic [7:0]           raw_neg_reg;
    logic signed [59:0]   sum_reg;
    logic [4:0]           s_reg;
    logic [31:0]          dhalf_reg;
    logic [32:0]          d_reg;
    logic signed [17:0]   wt_reg;
    logic                 m_valid_reg;
    logic [2:0]           tap_reg;
    logic signed [17:0]   weight_reg;
    logic                 last_reg;
    logic                 error_reg;

    logic                 out_free;
    logic [2:0]           tap_last;
    logic                 is_last;
    logic signed [20:0]   tap_off;
    logic signed [20:0]   t;
    logic [20:0]          t_abs;
    logic [32:0]          mul_a;
    logic [32:0]          mul_b;
    logic [65:0]          prod;
    logic [65:0]          prod_rnd;
    logic [35:0]          rnd;
    logic [32:0]          u_num;
    logic [31:0]          u;
    logic [29:0]          v_fold;
    logic [55:0]          q_mag;
    logic                 q_neg;
    logic [58:0]          sum_mag;
    logic [58:0]          sum_sh;
    logic [31:0]          dhalf_c;
    logic [58:0]          d_full;
    logic [56:0]          mm_full;
    logic [37:0]          mm;
    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [VW-1:0]        div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic signed [17:0]   wq;
    logic signed [39:0]   one40;
    logic [32:0]          p33;
    logic signed [39:0]   pf40;
    logic signed [17:0]   simple_w;
    logic                 simple_last;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // 2a taps for lanczos: 2a-1 from the low order bits
    always_comb begin
        case (kind_reg)
            lkw_pkg::K_NEAREST:  tap_last = 3'd0;
            lkw_pkg::K_BILINEAR: tap_last = 3'd1;
            lkw_pkg::K_INVALID:  tap_last = 3'd0;
            default:             tap_last = 3'({order_reg[1:0], 1'b0} - 3'd1);
        endcase
    end
    assign is_last = (k_reg == tap_last);

    // distance of tap k from the sample point
    assign tap_off = $signed({18'd0, order_reg}) - 21'sd1 - $signed({18'd0, k_reg});
    assign t       = $signed({5'd0, pos_reg}) + (tap_off <<< 16);
    assign t_abs   = t[20] ? 21'(-t) : 21'(t);

    assign u_num = {m_reg, 14'd0} + 33'(order_reg >> 1);

    always_comb begin
        case (state_reg)
            ST_UWAIT: begin mul_a = u_num;       mul_b = 33'h0_AAAA_AAAB; end
            ST_SQ:   begin mul_a = 33'(v_reg);  mul_b = 33'(v_reg); end
            ST_HORN: begin mul_a = 33'(v2_reg); mul_b = p_reg;      end
            ST_VP:   begin mul_a = 33'(v_reg);  mul_b = p_reg;      end
            ST_M2:   begin mul_a = 33'(m_reg);  mul_b = 33'(m_reg); end
            default: begin mul_a = '0;          mul_b = '0;         end
        endcase
    end
    assign prod     = 66'(mul_a) * 66'(mul_b);
    assign prod_rnd = prod + 66'(32'h2000_0000);
    assign rnd      = prod_rnd[65:30];

    // phase over a: shifts for orders 2 and 4, reciprocal multiply for order 3
    always_comb begin
        case (order_reg)
            lkw_pkg::MODE_LANCZOS2: u = u_num[32:1];
            lkw_pkg::MODE_LANCZOS3: u = prod[64:33];
            default:                u = 32'(u_num >> 2);
        endcase
    end

    // phase folded into the first quarter turn
    assign v_fold = (u > 32'h2000_0000) ? 30'(32'h4000_0000 - u) : u[29:0];

    assign q_mag = div_quo[55:0];
    assign q_neg = neg_reg ^ ~(order_reg[0] ^ k_reg[0]);

    assign sum_mag = sum_reg[58:0];
    assign sum_sh  = sum_mag >> s_reg;
    assign dhalf_c = (s_reg == 5'd0) ? 32'd0 : (32'd1 << (s_reg - 5'd1));
    assign d_full  = (sum_mag + 59'(dhalf_c)) >> s_reg;

    assign mm_full = (57'(raw_mag_reg[k_reg]) + 57'(dhalf_reg)) >> s_reg;
    assign mm      = (mm_full > 57'h20_0000_0000) ? 38'h20_0000_0000 : mm_full[37:0];

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_QDIV: begin
                div_start    = 1'b1;
                div_dividend = (DW'(sn_reg) << 24) + DW'(m2_reg >> 1);
                div_divisor  = m2_reg;
            end
            ST_WDIV: begin
                div_start    = 1'b1;
                div_dividend = (DW'(mm) << FRAC_BITS) + DW'(d_reg >> 1);
                div_divisor  = VW'(d_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    lkw_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quo      (div_quo)
    );

    // saturated signed weight from the quotient magnitude
    always_comb begin
        if (raw_neg_reg[k_reg]) begin
            wq = (div_quo > DW'(131072)) ? lkw_pkg::W_MIN : $signed(18'(-div_quo[17:0]));
        end else begin
            wq = (div_quo > DW'(131071)) ? lkw_pkg::W_MAX : $signed(div_quo[17:0]);
        end
    end

    assign one40 = 40'sd1 <<< FRAC_BITS;
    assign p33   = {1'b0, pos_reg, 16'd0} + (33'd1 << (31 - FRAC_BITS));
    assign pf40  = $signed(40'(p33 >> (32 - FRAC_BITS)));

    always_comb begin
        simple_last = is_last;
        case (kind_reg)
            lkw_pkg::K_NEAREST:  simple_w = lkw_pkg::sat18(one40);
            lkw_pkg::K_BILINEAR: begin
                simple_w = (k_reg == 3'd0) ? lkw_pkg::sat18(one40 - pf40)
                                           : lkw_pkg::sat18(pf40);
            end
            lkw_pkg::K_IMPULSE: begin
                simple_w = (k_reg == 3'(order_reg - 3'd1)) ? lkw_pkg::sat18(one40) : 18'sd0;
            end
            default:             simple_w = 18'sd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                kind_reg  <= q_item.kind;
                order_reg <= q_item.order;
                pos_reg   <= q_item.pos;
                sum_reg   <= '0;
            end
            ST_UDIV: begin
                m_reg   <= t_abs[18:0];
                neg_reg <= t[20];
            end
            ST_UWAIT: begin
                v_reg <= v_fold;
            end
            ST_SQ: begin
                v2_reg   <= rnd[28:0];
                p_reg    <= lkw_pkg::sin_coef(3'd6);
                hidx_reg <= 3'd5;
            end
            ST_HORN: begin
                p_reg    <= lkw_pkg::sin_coef(hidx_reg) - rnd[32:0];
                hidx_reg <= hidx_reg - 3'd1;
            end
            ST_VP: begin
                sn_reg <= rnd[30:0];
            end
            ST_M2: begin
                m2_reg <= prod[36:0];
            end
            ST_QWAIT: begin
                if (div_done) begin
                    raw_mag_reg[k_reg] <= q_mag;
                    raw_neg_reg[k_reg] <= q_neg;
                    sum_reg <= q_neg ? sum_reg - $signed({4'd0, q_mag})
                                     : sum_reg + $signed({4'd0, q_mag});
                end
            end
            ST_CHK: begin
                s_reg <= 5'd0;
                if (sum_reg <= 60'sd0) begin
                    kind_reg <= lkw_pkg::K_IMPULSE;
                end
            end
            ST_NORM: begin
                if (|sum_sh[58:32]) begin
                    s_reg <= s_reg + 5'd1;
                end else begin
                    dhalf_reg <= dhalf_c;
                    d_reg     <= d_full[32:0];
                end
            end
            ST_WWAIT: begin
                if (div_done) begin
                    wt_reg <= wq;
                end
            end
            default: begin
                hidx_reg <= hidx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    k_reg <= 3'd0;
                    if (q_valid) begin
                        state_reg <= (q_item.kind == lkw_pkg::K_LANCZOS) ? ST_UDIV : ST_SIMPLE;
                    end
                end
                ST_SIMPLE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        tap_reg     <= k_reg;
                        weight_reg  <= simple_w;
                        last_reg    <= simple_last;
                        error_reg   <= (kind_reg == lkw_pkg::K_INVALID);
                        k_reg       <= k_reg + 3'd1;
                        if (simple_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_UDIV:  state_reg <= ST_UWAIT;
                ST_UWAIT: state_reg <= ST_SQ;
                ST_SQ:    state_reg <= ST_HORN;
                ST_HORN: begin
                    if (hidx_reg == 3'd0) begin
                        state_reg <= ST_VP;
                    end
                end
                ST_VP:    state_reg <= ST_M2;
                ST_M2:    state_reg <= ST_QDIV;
                ST_QDIV:  state_reg <= ST_QWAIT;
                ST_QWAIT: begin
                    if (div_done) begin
                        if (is_last) begin
                            state_reg <= ST_CHK;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= ST_UDIV;
                        end
                    end
                end
                ST_CHK: begin
                    k_reg     <= 3'd0;
                    state_reg <= (sum_reg <= 60'sd0) ? ST_SIMPLE : ST_NORM;
                end
                ST_NORM: begin
                    if (!(|sum_sh[58:32])) begin
                        state_reg <= ST_WDIV;
                    end
                end
                ST_WDIV:  state_reg <= ST_WWAIT;
                ST_WWAIT: begin
                    if (div_done) begin
                        state_reg <= ST_WEMIT;
                    end
                end
                ST_WEMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        tap_reg     <= k_reg;
                        weight_reg  <= wt_reg;
                        last_reg    <= is_last;
                        error_reg   <= 1'b0;
                        k_reg       <= k_reg + 3'd1;
                        state_reg   <= is_last ? ST_IDLE : ST_WDIV;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tap_index = tap_reg;
    assign m_weight    = weight_reg;
    assign m_last      = last_reg;
    assign m_error     = error_reg;

endmodule

>>> design/lanczos_kernel_weights.sv
// Nearest, bilinear, zero shift and bad mode give one tap per cycle while the
// receiver is ready; lanczos computes each raw tap with the shared divider, then
// normalises the sum by shifts and divides again per tap; DW = max(56, FRAC_BITS+38)
// in the one-bit-a-cycle divider. Input: a two-entry queue takes items while the
// engine works. Reset: synchronous active-low aresetn empties the queue, idles the
// engine and drops any pending result.
// ----------------------------------------------------------------------------
// lanczos_kernel_weights: interpolation kernel weight generator
// Per fractional shift, emits nearest, bilinear or lanczos weights tap by tap; a bad mode gives an error tap.
// ----------------------------------------------------------------------------
module lanczos_kernel_weights #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_pos,
    input  logic [2:0]         s_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_tap_index,
    output logic signed [17:0] m_weight,
    output logic               m_last,
    output logic               m_error
);

    logic           q_valid;
    logic           q_pop;
    lkw_pkg::item_t q_item;

    lkw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pos   (s_pos),
        .s_mode  (s_mode),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    lkw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_tap_index (m_tap_index),
        .m_weight    (m_weight),
        .m_last      (m_last),
        .m_error     (m_error)
    );

`ifndef ASSERT_OFF
    // an error result is a lone zero tap
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_last && (m_tap_index == 3'd0) && (m_weight == 18'sd0))
        else $error("error result not a single zero tap");

    // the engine only takes an item that is queued
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a first tap only follows a last tap
    a_tap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !m_valid || (m_tap_index != 3'd0))
        else $error("kernel restarted before its last tap");
`endif

endmodule

>>> bench/lanczos_kernel_weights_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lanczos_kernel_weights_tb: self-checking bench for the kernel weight generator
// Drives shifts and kernel modes through the valid/ready input, predicts every
// tap in fixed point and compares each result transfer in order.
// ----------------------------------------------------------------------------
module lanczos_kernel_weights_tb;

    localparam int FB         = 16;
    localparam int WDOG_LIMIT = 40000;
    localparam int LONG_HOLD  = 3000;
    localparam int N_RANDOM   = 350;

    typedef struct {
        logic [2:0]         tap;
        logic signed [17:0] weight;
        logic               last;
        logic               err;
    } tap_t;

    class tap_scoreboard;
        tap_t taps_due[$];
        int   mismatches;
        int   taps_seen;
        int   items_noted;

        task report(string what, longint got, longint want);
            mismatches++;
            $display("mismatch at tap %0d: %s got %0d want %0d", taps_seen, what, got, want);
        endtask

        function void push_tap(int k, longint w, bit lst, bit er);
            tap_t t;
            if (w > 131071) w = 131071;
            if (w < -131072) w = -131072;
            t.tap = k[2:0];
            t.weight = w[17:0];
            t.last = lst;
            t.err = er;
            taps_due.push_back(t);
        endfunction

        function longint unsigned sin_pi(longint unsigned v);
            longint unsigned v2, p;
            v2 = (v * v + 64'd536870912) >> 30;
            p = lkw_pkg::sin_coef(3'd6);
            for (int i = 5; i >= 0; i--)
                p = lkw_pkg::sin_coef(i[2:0]) - ((v2 * p + 64'd536870912) >> 30);
            return (v * p + 64'd536870912) >> 30;
        endfunction

        function void push_impulse(int a);
            for (int k = 0; k < 2 * a; k++)
                push_tap(k, (k == a - 1) ? (64'sd1 <<< FB) : 0, k == 2 * a - 1, 0);
        endfunction

        function void push_lanczos(logic [15:0] pos, int a);
            longint raw[8];
            longint sum, t;
            longint unsigned m, u, sn, m2, q, d, dhalf, w;
            int s;
            bit neg;
            sum = 0;
            for (int k = 0; k < 2 * a; k++) begin
                t = longint'(pos) + longint'(a - 1 - k) * 65536;
                neg = t < 0;
                m = neg ? -t : t;
                u = (m * 16384 + a / 2) / a;
                if (u > 64'd536870912) u = 64'd1073741824 - u;
                sn = sin_pi(u);
                m2 = m * m;
                q = ((sn << 24) + m2 / 2) / m2;
                raw[k] = (neg != (((a + k + 1) & 1) != 0)) ? -longint'(q) : longint'(q);
                sum += raw[k];
            end
            if (sum <= 0) begin
                push_impulse(a);
                return;
            end
            s = 0;
            while ((longint'(unsigned'(sum)) >> s) >= 64'd4294967296) s++;
            dhalf = s ? (64'd1 << (s - 1)) : 0;
            d = (sum + dhalf) >> s;
            for (int k = 0; k < 2 * a; k++) begin
                neg = raw[k] < 0;
                m = neg ? -raw[k] : raw[k];
                m = (m + dhalf) >> s;
                if (m > (64'd1 << 37)) m = 64'd1 << 37;
                w = ((m << FB) + d / 2) / d;
                push_tap(k, neg ? -longint'(w) : longint'(w), k == 2 * a - 1, 0);
            end
        endfunction

        function void note_item(logic [15:0] pos, logic [2:0] mode);
            longint pf;
            items_noted++;
            case (mode)
                lkw_pkg::MODE_NEAREST: push_tap(0, 64'sd1 <<< FB, 1, 0);
                lkw_pkg::MODE_BILINEAR: begin
                    pf = ((longint'(pos) << 16) + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
                    push_tap(0, (64'sd1 <<< FB) - pf, 0, 0);
                    push_tap(1, pf, 1, 0);
                end
                lkw_pkg::MODE_LANCZOS2, lkw_pkg::MODE_LANCZOS3,
                lkw_pkg::MODE_LANCZOS4: begin
                    if (pos == 0) push_impulse(mode);
                    else push_lanczos(pos, mode);
                end
                default: push_tap(0, 0, 1, 1);
            endcase
        endfunction

        task check_tap(logic [2:0] tap, logic signed [17:0] w, logic lst, logic er);
            tap_t e;
            taps_seen++;
            if (taps_due.size() == 0) begin
                report("unexpected result, tap", tap, -1);
                return;
            end
            e = taps_due.pop_front();
            if (tap !== e.tap) report("tap_index", tap, e.tap);
            if (w !== e.weight) report("weight", w, e.weight);
            if (lst !== e.last) report("last", lst, e.last);
            if (er !== e.err) report("error", er, e.err);
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_pos;
    logic [2:0]         s_mode;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_tap_index;
    logic signed [17:0] m_weight;
    logic               m_last;
    logic               m_error;

    tap_scoreboard sb;
    bit  quiet;
    bit  hold_req;
    int  idle_cycles;

    lanczos_kernel_weights dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_item(logic [15:0] pos, logic [2:0] mode);
        int gap;
        @(negedge aclk);
        s_valid = 1;
        s_pos = pos;
        s_mode = mode;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(pos, mode);
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_valid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (sb.taps_due.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        bit held;
        held = 0;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held = 1;
                m_ready = 0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready = 1;
            end else if (!quiet && $urandom_range(4) == 0) begin
                n = $urandom_range(1, 10);
                m_ready = 0;
                repeat (n - 1) @(negedge aclk);
                m_ready = 1;
            end else begin
                m_ready = 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_tap(m_tap_index, m_weight, m_last, m_error);
    end

    // watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("lanczos_kernel_weights_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] p;
        logic [2:0]  md;
        int r;
        sb = new();
        aresetn = 0;
        s_valid = 0;
        s_pos = 0;
        s_mode = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes of shift for every mode, zero shift, bad modes
        for (int md_i = 0; md_i < 5; md_i++) begin
            send_item(16'd0, md_i[2:0]);
            send_item(16'd1, md_i[2:0]);
            send_item(16'h8000, md_i[2:0]);
            send_item(16'hffff, md_i[2:0]);
        end
        send_item(16'h1234, 3'd5);
        send_item(16'hffff, 3'd6);
        send_item(16'h0000, 3'd7);

        // sender pauses until the block is drained
        @(negedge aclk);
        s_valid = 0;
        wait_drained();

        // long receiver hold-off while fast items keep coming
        hold_req = 1;
        for (int i = 0; i < 12; i++)
            send_item(16'($urandom),
                      (i % 3 == 0) ? lkw_pkg::MODE_LANCZOS2 : lkw_pkg::MODE_NEAREST);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 60) quiet = 1;
            r = $urandom_range(99);
            if (r < 20) md = lkw_pkg::MODE_NEAREST;
            else if (r < 40) md = lkw_pkg::MODE_BILINEAR;
            else if (r < 60) md = lkw_pkg::MODE_LANCZOS2;
            else if (r < 75) md = lkw_pkg::MODE_LANCZOS3;
            else if (r < 87) md = lkw_pkg::MODE_LANCZOS4;
            else md = 3'($urandom_range(5, 7));
            r = $urandom_range(19);
            if (r == 0) p = 16'd0;
            else if (r == 1) p = 16'($urandom_range(1, 16));
            else if (r == 2) p = 16'hffff - 16'($urandom_range(15));
            else p = 16'($urandom);
            send_item(p, md);
        end
        @(negedge aclk);
        s_valid = 0;
        wait_drained();
        repeat (2500) @(posedge aclk);

        $display("covered %0d shifts over all kernel modes, %0d taps checked",
                 sb.items_noted, sb.taps_seen);
        if (sb.mismatches == 0 && sb.taps_due.size() == 0) begin
            $display("lanczos_kernel_weights_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d taps missing", sb.mismatches, sb.taps_due.size());
            $display("lanczos_kernel_weights_tb: FAIL");
        end
        $finish;
    end

endmodule
